/* rtl/core/fac_pkg.sv */
// Package for the floating accumulator format converter.
// Holds widths, action and status codes and the leading-one helper. No dependencies.
`default_nettype none
package fac_pkg;
    localparam int MANTISSA_BYTES_DEF = 4;
    localparam int EXP_BIAS = 128;

    typedef enum logic [1:0] {
        ACT_LOAD      = 2'd0,
        ACT_CONVERT   = 2'd1,
        ACT_READ      = 2'd2,
        ACT_NORMALIZE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_WRAP   = 2'd1,
        ST_REJECT = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    // Index of the highest set bit of a 64-bit word; zero for a zero word.
    function automatic logic [5:0] top_bit64(input logic [63:0] x);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/fac_datapath.sv */
// Combinational datapath of the converter: computes the next accumulator,
// the read-out double and the status for one action. Uses fac_pkg.
`default_nettype none
module fac_datapath #(
    parameter int MANTISSA_BYTES = fac_pkg::MANTISSA_BYTES_DEF
) (
    input  wire logic [1:0]                    action,
    input  wire logic [63:0]                   double_bits,
    input  wire logic                          raw_sign,
    input  wire logic [7:0]                    raw_exponent,
    input  wire logic [31:0]                   raw_mantissa,
    input  wire logic                          acc_sign,
    input  wire logic [7:0]                    acc_exponent,
    input  wire logic [8*MANTISSA_BYTES-1:0]   acc_mantissa,
    output logic                               sign_next,
    output logic [7:0]                         exponent_next,
    output logic [8*MANTISSA_BYTES-1:0]        mantissa_next,
    output logic [63:0]                        result_double,
    output logic [1:0]                         status
);
    import fac_pkg::*;
    localparam int MB = 8 * MANTISSA_BYTES;

    logic        in_s;
    logic [10:0] in_e;
    logic [51:0] in_f;
    logic [5:0]  fp;
    logic [52:0] sig;
    logic [12:0] biased;
    logic [5:0]  mp;
    logic [12:0] de;
    logic [63:0] m64;
    logic [63:0] msh;
    logic [5:0]  lz;
    logic [7:0]  sh;
    logic [63:0] rawm64;

    always_comb
    begin
        in_s   = double_bits[63];
        in_e   = double_bits[62:52];
        in_f   = double_bits[51:0];
        fp     = top_bit64({12'd0, in_f});
        m64    = 64'(acc_mantissa);
        mp     = top_bit64(m64);
        rawm64 = {32'd0, raw_mantissa};
        if (in_e != 11'd0)
        begin
            sig    = {1'b1, in_f};
            biased = 13'(in_e) - 13'd1022 + 13'(EXP_BIAS);
        end
        else
        begin
            sig    = 53'({1'b0, in_f} << (6'd52 - fp));
            biased = 13'(fp) - 13'd1073 + 13'(EXP_BIAS);
        end
        de  = 13'(mp) + 13'(acc_exponent) - 13'(EXP_BIAS) - 13'(MB) + 13'd1023;
        msh = m64 << (6'd52 - mp);
        lz  = 6'(MB - 1) - mp;
        sh  = (8'(lz) < acc_exponent) ? 8'(lz) : acc_exponent;

        sign_next     = acc_sign;
        exponent_next = acc_exponent;
        mantissa_next = acc_mantissa;
        result_double = 64'd0;
        status        = ST_OK;
        unique case (action_t'(action))
            ACT_LOAD:
            begin
                sign_next     = raw_sign;
                exponent_next = raw_exponent;
                mantissa_next = rawm64[MB-1:0];
            end
            ACT_CONVERT:
            begin
                if (in_e == 11'h7FF)
                begin
                    status = ST_REJECT;
                end
                else if (in_e == 11'd0 && in_f == 52'd0)
                begin
                    sign_next     = 1'b0;
                    exponent_next = 8'd0;
                    mantissa_next = '0;
                end
                else
                begin
                    sign_next     = in_s;
                    exponent_next = biased[7:0];
                    mantissa_next = sig[52 -: MB];
                    if ($signed(biased) < 13'sd1 || $signed(biased) > 13'sd255)
                    begin
                        status = ST_WRAP;
                    end
                end
            end
            ACT_READ:
            begin
                if (acc_exponent == 8'd0)
                begin
                    result_double = 64'd0;
                end
                else if (acc_mantissa == '0)
                begin
                    result_double = {acc_sign, 63'd0};
                end
                else
                begin
                    result_double = {acc_sign, de[10:0], msh[51:0]};
                end
            end
            ACT_NORMALIZE:
            begin
                if (acc_mantissa == '0)
                begin
                    exponent_next = 8'd0;
                    sign_next     = 1'b0;
                end
                else
                begin
                    mantissa_next = acc_mantissa << sh;
                    exponent_next = acc_exponent - sh;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/core/fac_float_format_converter.sv */
// Top level of the floating accumulator format converter: input register,
// accumulator, result register with stream handshakes. Uses fac_pkg, fac_datapath.
`default_nettype none
// One transaction per clock while the output is not stalled: an accepted item
// is registered, processed by combinational logic against the accumulator and
// its result lands in an output register when that register can take it. Input is
// accepted whenever the output register is empty or being drained, so throughput is
// one item per cycle while that holds. The accumulator resets to zero.
module fac_float_format_converter #(
    parameter int MANTISSA_BYTES = fac_pkg::MANTISSA_BYTES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // action[1:0], double_bits[65:2], raw_sign[66], raw_exponent[74:67],
    // raw_mantissa[106:75], zero fill to 112
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_double[63:0], acc_sign[64], acc_exponent[72:65],
    // acc_mantissa[104:73], status[106:105], zero fill to 112
    output logic [111:0]      m_tdata
);
    import fac_pkg::*;
    localparam int MB = 8 * MANTISSA_BYTES;

    logic          in_valid_reg;
    logic [106:0]  in_data_reg;
    logic          out_valid_reg;
    logic [106:0]  out_data_reg;
    logic          acc_sign_reg;
    logic [7:0]    acc_exponent_reg;
    logic [MB-1:0] acc_mantissa_reg;
    logic          sign_next;
    logic [7:0]    exponent_next;
    logic [MB-1:0] mantissa_next;
    logic [63:0]   dbl;
    logic [1:0]    st;
    logic          stage_go;
    logic [63:0]   mant_out;

    // The work stage moves whenever the output register can take its result.
    assign stage_go = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || stage_go;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg};
    assign mant_out = 64'(mantissa_next);

    fac_datapath #(.MANTISSA_BYTES(MANTISSA_BYTES)) u_dp (
        .action        (in_data_reg[1:0]),
        .double_bits   (in_data_reg[65:2]),
        .raw_sign      (in_data_reg[66]),
        .raw_exponent  (in_data_reg[74:67]),
        .raw_mantissa  (in_data_reg[106:75]),
        .acc_sign      (acc_sign_reg),
        .acc_exponent  (acc_exponent_reg),
        .acc_mantissa  (acc_mantissa_reg),
        .sign_next     (sign_next),
        .exponent_next (exponent_next),
        .mantissa_next (mantissa_next),
        .result_double (dbl),
        .status        (st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            acc_sign_reg     <= 1'b0;
            acc_exponent_reg <= 8'd0;
            acc_mantissa_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (stage_go)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    acc_sign_reg     <= sign_next;
                    acc_exponent_reg <= exponent_next;
                    acc_mantissa_reg <= mantissa_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata[106:0];
        end
        if (stage_go && in_valid_reg)
        begin
            out_data_reg <= {st, mant_out[31:0], exponent_next, sign_next, dbl};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(out_data_reg))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> $stable(acc_exponent_reg) && $stable(acc_mantissa_reg))
        else $error("accumulator changed with no item");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[106:105] == ST_REJECT |-> out_data_reg[63:0] == 64'd0)
        else $error("rejected item produced a double");
endmodule
`default_nettype wire
